### sv/assert_macros.svh
// Assertion macros shared by the detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define BCHD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Antecedent in any cycle implies the consequent in the next cycle.
`define BCHD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BCHD_ASSERT(lbl, prop)
`define BCHD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/bchd_pkg.sv
// Types and constants of the button click and hold detector.
`timescale 1ns / 1ps
`default_nettype none
package bchd_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] RegHoldMin  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegRelease  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegDebounce = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CfgDataWidth-1:0] HoldMinReset  = 16'd500;
  localparam logic [CfgDataWidth-1:0] ReleaseReset  = 16'd200;
  localparam logic [CfgDataWidth-1:0] DebounceReset = 16'd50;

  // Current configuration.
  typedef struct packed {
    logic [CfgDataWidth-1:0] hold_min_ms;
    logic [CfgDataWidth-1:0] release_ms;
    logic [CfgDataWidth-1:0] debounce_ms;
  } cfg_t;

  // One poll request.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        edge_seen;
    logic        pin_high;
  } item_t;

  // One poll result.
  typedef struct packed {
    logic        finish_valid;
    logic        finish_is_hold;
    logic [7:0]  finish_count;
    logic        hold_valid;
    logic [7:0]  hold_count;
    logic [31:0] hold_ms;
  } result_t;

endpackage
`default_nettype wire

### sv/button_click_hold_detector.sv
// Top level of the button click and hold detector: input and result registers.
// An accepted request enters the input register, then moves on to the result register.
// Throughput: one request per cycle unless the result is stalled; the state update is a
// single pass of subtract-and-compare logic between the input and result registers.
// A stalled result holds the result register and the input register fills behind it.
// Reset (asynchronous, active low) clears the state and the valids, not the data registers.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module button_click_hold_detector #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write channel.
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [bchd_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [bchd_pkg::CfgDataWidth-1:0] cfg_data_i,
  // Poll requests.
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [31:0]                       now_ms_i,
  input  wire logic                              edge_seen_i,
  input  wire logic                              pin_high_i,
  // Poll results.
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic                              finish_valid_o,
  output      logic                              finish_is_hold_o,
  output      logic [7:0]                        finish_count_o,
  output      logic                              hold_valid_o,
  output      logic [7:0]                        hold_count_o,
  output      logic [31:0]                       hold_ms_o
);

  bchd_pkg::cfg_t    cfg;
  bchd_pkg::item_t   item_q;
  bchd_pkg::result_t res;
  bchd_pkg::result_t res_q;
  logic              item_v_q;
  logic              res_v_q;
  logic              advance;
  logic              step;
  logic              in_fire;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;

  bchd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline handshake.
  assign advance    = !res_v_q || out_ready_i;
  assign step       = item_v_q && advance;
  assign in_ready_o = !item_v_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else if (in_ready_o) begin
      item_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.now_ms    <= now_ms_i;
      item_q.edge_seen <= edge_seen_i;
      item_q.pin_high  <= pin_high_i;
    end
  end

  bchd_step #(
    .TimeWidth (TIME_WIDTH)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (advance) begin
      res_v_q <= item_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = res_v_q;
  assign finish_valid_o   = res_q.finish_valid;
  assign finish_is_hold_o = res_q.finish_is_hold;
  assign finish_count_o   = res_q.finish_count;
  assign hold_valid_o     = res_q.hold_valid;
  assign hold_count_o     = res_q.hold_count;
  assign hold_ms_o        = res_q.hold_ms;

  // A processed request always shows up as a result in the next cycle.
  `BCHD_ASSERT_NEXT(a_step_gives_result, step, res_v_q)
  // A request waiting behind a stalled result is kept.
  `BCHD_ASSERT_NEXT(a_stall_keeps_item, item_v_q && !advance, item_v_q)
  // An accepted request is in the input register in the next cycle.
  `BCHD_ASSERT_NEXT(a_accept_fills_input, in_fire, item_v_q)

endmodule
`default_nettype wire

### sv/bchd_cfg.sv
// Configuration register file of the detector.
`timescale 1ns / 1ps
`default_nettype none
module bchd_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [bchd_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [bchd_pkg::CfgDataWidth-1:0] cfg_data_i,
  output bchd_pkg::cfg_t                         cfg_o
);

  bchd_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bchd_pkg::RegHoldMin:  cfg_d.hold_min_ms = cfg_data_i;
        bchd_pkg::RegRelease:  cfg_d.release_ms  = cfg_data_i;
        bchd_pkg::RegDebounce: cfg_d.debounce_ms = cfg_data_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_min_ms <= bchd_pkg::HoldMinReset;
      cfg_q.release_ms  <= bchd_pkg::ReleaseReset;
      cfg_q.debounce_ms <= bchd_pkg::DebounceReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### sv/bchd_step.sv
// Detector state and the per-poll update logic.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bchd_step #(
  parameter int unsigned TimeWidth = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire bchd_pkg::item_t  item_i,
  input  wire bchd_pkg::cfg_t   cfg_i,
  output bchd_pkg::result_t     res_o
);

  logic                 latch_q, latch_d;
  logic                 pressed_q, pressed_d;
  logic [7:0]           count_q, count_d;
  logic [TimeWidth-1:0] hold_start_q, hold_start_d;
  logic [TimeWidth-1:0] last_press_q, last_press_d;

  logic [TimeWidth-1:0] now;
  logic [TimeWidth-1:0] since_last;
  logic [TimeWidth-1:0] held;
  logic [TimeWidth-1:0] hold_min;
  logic [TimeWidth-1:0] release_lim;
  logic [TimeWidth-1:0] release_half;
  logic [TimeWidth-1:0] debounce;
  logic                 long_press;
  logic                 fin;
  logic [7:0]           count_fin;

  // Time values wrap at the configured time width.
  assign now          = item_i.now_ms[TimeWidth-1:0];
  assign since_last   = now - last_press_q;
  assign held         = now - hold_start_q;
  assign hold_min     = TimeWidth'(cfg_i.hold_min_ms);
  assign release_lim  = TimeWidth'(cfg_i.release_ms);
  assign release_half = TimeWidth'(cfg_i.release_ms >> 1);
  assign debounce     = TimeWidth'(cfg_i.debounce_ms);

  assign long_press = pressed_q && (held > hold_min);
  assign fin        = (since_last > release_lim) || (long_press && (since_last > release_half));
  assign count_fin  = fin ? 8'd0 : count_q;

  // Next state: finish the series first, then register the press.
  always_comb begin
    latch_d      = (latch_q | item_i.edge_seen) & ~item_i.pin_high;
    pressed_d    = fin ? 1'b0 : pressed_q;
    count_d      = count_fin;
    hold_start_d = fin ? now : hold_start_q;
    last_press_d = last_press_q;
    if (latch_d) begin
      if ((since_last > debounce) && !long_press) begin
        count_d      = count_fin + 8'd1;
        hold_start_d = now;
      end
      last_press_d = now;
      pressed_d    = 1'b1;
    end
  end

  // State advances only when a poll is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q      <= 1'b0;
      pressed_q    <= 1'b0;
      count_q      <= 8'd0;
      hold_start_q <= '0;
      last_press_q <= '0;
    end else if (step_i) begin
      latch_q      <= latch_d;
      pressed_q    <= pressed_d;
      count_q      <= count_d;
      hold_start_q <= hold_start_d;
      last_press_q <= last_press_d;
    end
  end

  // Result of the poll; unused fields read as zero.
  always_comb begin
    res_o.finish_valid   = fin;
    res_o.finish_is_hold = fin && long_press;
    res_o.finish_count   = fin ? count_q : 8'd0;
    res_o.hold_valid     = long_press;
    res_o.hold_count     = long_press ? count_d : 8'd0;
    res_o.hold_ms        = long_press ? 32'(held) : 32'd0;
  end

  // A hold end is always reported together with the ongoing hold.
  `BCHD_ASSERT(a_hold_end_has_hold, !res_o.finish_is_hold || res_o.hold_valid)
  // A finish during a hold restarts the click count from zero.
  `BCHD_ASSERT(a_hold_end_count_zero, !res_o.finish_is_hold || res_o.hold_count == 8'd0)
  // A processed poll that leaves the latch set marks the button as pressed.
  `BCHD_ASSERT_NEXT(a_latch_sets_pressed, step_i && latch_d, pressed_q)

endmodule
`default_nettype wire

### verif/bchd_poll_checker.sv
// Checker that predicts and compares the poll results of the click and hold detector.
`timescale 1ns / 1ps
module bchd_poll_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [bchd_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [bchd_pkg::CfgDataWidth-1:0] cfg_data_i,
  // Poll requests.
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [31:0]                       now_ms_i,
  input  logic                              edge_seen_i,
  input  logic                              pin_high_i,
  // Poll results.
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic                              finish_valid_i,
  input  logic                              finish_is_hold_i,
  input  logic [7:0]                        finish_count_i,
  input  logic                              hold_valid_i,
  input  logic [7:0]                        hold_count_i,
  input  logic [31:0]                       hold_ms_i,
  // Status for the testbench top.
  output int                                mismatch_count_o,
  output int                                pending_o,
  output int                                checked_o,
  output int                                series_ends_o,
  output int                                hold_ends_o,
  output int                                hold_polls_o
);

  // Predicted copy of the detector's registers and state.
  bchd_pkg::cfg_t cfg;
  logic           press_latched;
  logic [7:0]     clicks;
  logic [31:0]    hold_start;
  logic [31:0]    last_press;
  logic           pressed;

  // Results predicted for accepted polls, oldest first.
  bchd_pkg::result_t expected_results[$];

  int          n_mismatch   = 0;
  int          n_checked    = 0;
  int          n_ends       = 0;
  int          n_hold_ends  = 0;
  int          n_hold_polls = 0;

  assign mismatch_count_o = n_mismatch;
  assign checked_o        = n_checked;
  assign series_ends_o    = n_ends;
  assign hold_ends_o      = n_hold_ends;
  assign hold_polls_o     = n_hold_polls;

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what);
    n_mismatch++;
    $display("%0t ns: poll result mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Advance the predicted state by one poll and queue the result it yields.
  task automatic predict_poll(input logic [31:0] now, input logic press_edge,
                              input logic pin_up);
    logic [31:0]       since_last;
    logic [31:0]       held;
    logic              long_press;
    bchd_pkg::result_t res;
    res = '0;
    // An edge latches the press; a released pin clears it in the same poll.
    if (press_edge) press_latched = 1'b1;
    if (press_latched && pin_up) press_latched = 1'b0;
    since_last = now - last_press;
    held       = now - hold_start;
    long_press = pressed && (held > {16'd0, cfg.hold_min_ms});
    // The series ends after the release time, or half of it during a long hold.
    if ((since_last > {16'd0, cfg.release_ms}) ||
        (long_press && (since_last > {17'd0, cfg.release_ms[15:1]}))) begin
      res.finish_valid   = 1'b1;
      res.finish_is_hold = long_press;
      res.finish_count   = clicks;
      clicks     = 8'd0;
      pressed    = 1'b0;
      hold_start = now;
    end
    // A press past the debounce gap adds a click unless a long hold is running.
    if (press_latched) begin
      if ((since_last > {16'd0, cfg.debounce_ms}) && !long_press) begin
        clicks     = clicks + 8'd1;
        hold_start = now;
      end
      last_press = now;
      pressed    = 1'b1;
    end
    if (long_press) begin
      res.hold_valid = 1'b1;
      res.hold_count = clicks;
      res.hold_ms    = held;
    end
    expected_results.push_back(res);
  endtask

  // Compare one accepted result with the oldest prediction.
  task automatic compare_result();
    bchd_pkg::result_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch("result arrived with no poll outstanding");
    end else begin
      want = expected_results.pop_front();
      n_checked++;
      if (want.finish_valid) n_ends++;
      if (want.finish_is_hold) n_hold_ends++;
      if (want.hold_valid) n_hold_polls++;
      check_field("finish_valid", 32'(finish_valid_i), 32'(want.finish_valid));
      check_field("finish_is_hold", 32'(finish_is_hold_i), 32'(want.finish_is_hold));
      check_field("finish_count", 32'(finish_count_i), 32'(want.finish_count));
      check_field("hold_valid", 32'(hold_valid_i), 32'(want.hold_valid));
      check_field("hold_count", 32'(hold_count_i), 32'(want.hold_count));
      check_field("hold_ms", hold_ms_i, want.hold_ms);
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.hold_min_ms = bchd_pkg::HoldMinReset;
      cfg.release_ms  = bchd_pkg::ReleaseReset;
      cfg.debounce_ms = bchd_pkg::DebounceReset;
      press_latched   = 1'b0;
      clicks          = 8'd0;
      hold_start      = 32'd0;
      last_press      = 32'd0;
      pressed         = 1'b0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) compare_result();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bchd_pkg::RegHoldMin:  cfg.hold_min_ms = cfg_data_i;
          bchd_pkg::RegRelease:  cfg.release_ms  = cfg_data_i;
          bchd_pkg::RegDebounce: cfg.debounce_ms = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_poll(now_ms_i, edge_seen_i, pin_high_i);
      pending_o <= expected_results.size();
    end
  end

endmodule

### verif/tb_button_click_hold_detector.sv
// Testbench top for the button click and hold detector: stimulus and verdict.
`timescale 1ns / 1ps
module tb_button_click_hold_detector;

  // Cycles without any accepted request before the run is declared hung.
  localparam int unsigned WatchdogLimit = 5000;
  // Index outside the register list; the block ignores writes to it.
  localparam logic [bchd_pkg::CfgIdxWidth-1:0] RegSpare = 2'd3;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [bchd_pkg::CfgIdxWidth-1:0]  cfg_index_i;
  logic [bchd_pkg::CfgDataWidth-1:0] cfg_data_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic [31:0]                       now_ms_i;
  logic                              edge_seen_i;
  logic                              pin_high_i;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic                              finish_valid_o;
  logic                              finish_is_hold_o;
  logic [7:0]                        finish_count_o;
  logic                              hold_valid_o;
  logic [7:0]                        hold_count_o;
  logic [31:0]                       hold_ms_o;

  int          mismatches;
  int          pending;
  int          checked;
  int          series_ends;
  int          hold_ends;
  int          hold_polls;
  int unsigned polls_sent   = 0;
  int unsigned settings_run = 0;
  int unsigned idle_cycles  = 0;
  bit          steady       = 1'b0;
  logic [31:0] t_ms;

  button_click_hold_detector #(
    .TIME_WIDTH(32)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .now_ms_i        (now_ms_i),
    .edge_seen_i     (edge_seen_i),
    .pin_high_i      (pin_high_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .finish_valid_o  (finish_valid_o),
    .finish_is_hold_o(finish_is_hold_o),
    .finish_count_o  (finish_count_o),
    .hold_valid_o    (hold_valid_o),
    .hold_count_o    (hold_count_o),
    .hold_ms_o       (hold_ms_o)
  );

  bchd_poll_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .now_ms_i        (now_ms_i),
    .edge_seen_i     (edge_seen_i),
    .pin_high_i      (pin_high_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .finish_valid_i  (finish_valid_o),
    .finish_is_hold_i(finish_is_hold_o),
    .finish_count_i  (finish_count_o),
    .hold_valid_i    (hold_valid_o),
    .hold_count_i    (hold_count_o),
    .hold_ms_i       (hold_ms_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending),
    .checked_o       (checked),
    .series_ends_o   (series_ends),
    .hold_ends_o     (hold_ends),
    .hold_polls_o    (hold_polls)
  );

  // 100 MHz clock.
  always #5 clk_i = ~clk_i;

  // The result side stalls with a chance of 16 in a hundred, except in steady stretches.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 16);
  end

  // Watchdog: end the run if no request moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog: no request accepted for %0d cycles.", idle_cycles);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Time step for the next poll: mostly short, sometimes long, rarely anywhere.
  function automatic logic [31:0] pick_step(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, span / 8 + 1);
    if (r < 85) return $urandom_range(0, span + 1);
    if (r < 95) return $urandom_range(span, 3 * span + 2);
    return $urandom;
  endfunction

  // Issue one poll request, with random idle cycles ahead of it.
  task automatic send_poll(input logic [31:0] now_v, input logic press_v,
                           input logic pin_v);
    while (!steady && ($urandom_range(0, 99) < 16)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    now_ms_i    <= now_v;
    edge_seen_i <= press_v;
    pin_high_i  <= pin_v;
    do @(posedge clk_i); while (!in_ready_o);
    polls_sent++;
  endtask

  // Wait until every predicted result has come out and the pipeline is empty.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all three registers, and the unused index if asked.
  task automatic write_config(input logic [15:0] hold_v, input logic [15:0] rel_v,
                              input logic [15:0] deb_v, input bit spare);
    logic [bchd_pkg::CfgIdxWidth-1:0]  idx [4];
    logic [bchd_pkg::CfgDataWidth-1:0] val [4];
    int                                n;
    idx[0] = bchd_pkg::RegHoldMin;
    val[0] = hold_v;
    idx[1] = bchd_pkg::RegRelease;
    val[1] = rel_v;
    idx[2] = bchd_pkg::RegDebounce;
    val[2] = deb_v;
    idx[3] = RegSpare;
    val[3] = 16'($urandom);
    n = spare ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  // Mostly press series with random timing, some idle polls and some noise.
  task automatic run_sequences(input int unsigned span, input int unsigned n_items);
    int unsigned start;
    int unsigned kind;
    int unsigned n_clicks;
    int unsigned n_hold;
    start = polls_sent;
    while (polls_sent - start < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        n_clicks = $urandom_range(1, 4);
        repeat (n_clicks) begin
          t_ms += pick_step(span);
          send_poll(t_ms, 1'b1, 1'b0);
          // Now and then hold the button long enough to become a long hold.
          n_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                               : $urandom_range(0, 3);
          repeat (n_hold) begin
            t_ms += $urandom_range(0, span / 8 + 1);
            send_poll(t_ms, $urandom_range(0, 7) == 0, 1'b0);
          end
          t_ms += pick_step(span);
          send_poll(t_ms, $urandom_range(0, 3) == 0, 1'b1);
        end
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 5)) begin
          t_ms += pick_step(span);
          send_poll(t_ms, $urandom_range(0, 7) == 0, 1'b1);
        end
      end else begin
        send_poll($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // One register setting followed by random series scaled to its time values.
  task automatic run_phase(input logic [15:0] hold_v, input logic [15:0] rel_v,
                           input logic [15:0] deb_v, input bit spare,
                           input int unsigned n_items, input bit quiet);
    int unsigned span;
    wait_drained();
    write_config(hold_v, rel_v, deb_v, spare);
    span = 8;
    if (hold_v > span) span = 32'(hold_v);
    if (rel_v > span) span = 32'(rel_v);
    if (deb_v > span) span = 32'(deb_v);
    steady <= quiet;
    run_sequences(span, n_items);
    steady <= 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    now_ms_i    = '0;
    edge_seen_i = 1'b0;
    pin_high_i  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed polls with the reset settings: bounce, clicks, empty end, hold, wrap.
    send_poll(32'd0, 1'b0, 1'b0);
    send_poll(32'd10, 1'b1, 1'b1);
    send_poll(32'd100, 1'b1, 1'b0);
    send_poll(32'd120, 1'b0, 1'b0);
    send_poll(32'd130, 1'b0, 1'b1);
    send_poll(32'd200, 1'b1, 1'b0);
    send_poll(32'd210, 1'b0, 1'b1);
    send_poll(32'd230, 1'b1, 1'b0);
    send_poll(32'd240, 1'b0, 1'b1);
    send_poll(32'd441, 1'b0, 1'b1);
    send_poll(32'd442, 1'b0, 1'b1);
    send_poll(32'd1000, 1'b1, 1'b0);
    for (int k = 1; k <= 7; k++) send_poll(32'd1000 + 32'(100 * k), 1'b0, 1'b0);
    send_poll(32'd1710, 1'b0, 1'b1);
    send_poll(32'd1811, 1'b0, 1'b1);
    send_poll(32'hFFFF_FFF0, 1'b1, 1'b0);
    send_poll(32'h0000_0010, 1'b0, 1'b1);
    send_poll(32'h0000_0100, 1'b0, 1'b1);
    send_poll(32'hFFFF_FFFF, 1'b1, 1'b1);

    // Typical settings, first with idling and then a long steady stretch.
    t_ms = $urandom;
    run_phase(16'($urandom_range(200, 900)), 16'($urandom_range(80, 400)),
              16'($urandom_range(5, 60)), 1'b0, 300, 1'b0);
    run_phase(16'($urandom_range(200, 900)), 16'($urandom_range(80, 400)),
              16'($urandom_range(5, 60)), 1'b0, 200, 1'b1);

    // Extremes: every register at zero, then every register at its maximum near a wrap.
    run_phase(16'd0, 16'd0, 16'd0, 1'b0, 100, 1'b0);
    t_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 180, 1'b0);

    // Fully random register values, plus a write to the unused index.
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 1'b1, 150, 1'b0);

    // Click counter overflow: more than 256 clicks in one series, then its end.
    wait_drained();
    write_config(16'hFFFF, 16'hFFFF, 16'd0, 1'b1);
    t_ms = $urandom;
    repeat (262) begin
      t_ms += 1;
      send_poll(t_ms, 1'b1, 1'b0);
    end
    t_ms += 70000;
    send_poll(t_ms, 1'b0, 1'b1);

    // Back to the reset values.
    run_phase(bchd_pkg::HoldMinReset, bchd_pkg::ReleaseReset, bchd_pkg::DebounceReset,
              1'b0, 120, 1'b0);

    wait_drained();
    $display("Sent %0d polls under %0d register settings, zero and maximum among them.",
             polls_sent, settings_run);
    $display("Checked %0d results: %0d series ends (%0d after a long hold), %0d hold polls.",
             checked, series_ends, hold_ends, hold_polls);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/bchd_pkg.sv
sv/bchd_cfg.sv
sv/bchd_step.sv
sv/button_click_hold_detector.sv
verif/bchd_poll_checker.sv
verif/tb_button_click_hold_detector.sv
